// ===== hw/rtl/xstg_pkg.sv =====
package xstg_pkg;

  localparam int unsigned MemSizeWidth = 33;
  localparam logic [MemSizeWidth-1:0] MEM_SIZE_RESET = 33'd268435456;
  localparam logic [64:0] BOUND_SPAN = 65'd10;
  localparam logic [3:0] LONG_TABLE_BYTES = 4'd10;
  localparam logic [3:0] SHORT_TABLE_BYTES = 4'd6;
  localparam logic [3:0] MSW_STORE_BYTES = 4'd2;
  localparam logic [63:0] MASK24 = 64'h0000_0000_00ff_ffff;
  localparam logic [63:0] MASK32 = 64'h0000_0000_ffff_ffff;

  typedef enum logic [2:0] {
    STATUS_DONE   = 3'd0,
    STATUS_UD     = 3'd1,
    STATUS_SEGV   = 3'd2,
    STATUS_RDTSCP = 3'd3,
    STATUS_INVAL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_WIDTH_16 = 2'd0,
    REG_WIDTH_32 = 2'd1,
    REG_WIDTH_64 = 2'd2
  } reg_width_e;

  typedef enum logic [2:0] {
    GRP_SGDT   = 3'd0,
    GRP_SIDT   = 3'd1,
    GRP_LGDT   = 3'd2,
    GRP_LIDT   = 3'd3,
    GRP_SMSW   = 3'd4,
    GRP_RSVD   = 3'd5,
    GRP_LMSW   = 3'd6,
    GRP_INVLPG = 3'd7
  } grp_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_UD,
    OP_SEGV,
    OP_RDTSCP,
    OP_INVAL,
    OP_STORE_GDT,
    OP_STORE_IDT,
    OP_LOAD_GDT,
    OP_LOAD_IDT,
    OP_SMSW_MEM,
    OP_SMSW_REG,
    OP_LMSW
  } op_e;

  typedef struct packed {
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        is_memory;
    logic        long_mode;
    logic        operand16;
    logic        rex_w;
    logic [63:0] address;
    logic [15:0] loaded_limit;
    logic [63:0] loaded_base;
    logic [15:0] source_word;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        mem_write;
    logic [3:0]  write_length;
    logic [15:0] write_limit;
    logic [63:0] write_base;
    logic [3:0]  read_length;
    logic        reg_write;
    reg_width_e  reg_width;
    logic [63:0] reg_value;
  } rsp_t;

  // classified command between front and back
  typedef struct packed {
    op_e         op;
    logic        long_mode;
    logic        operand16;
    logic        rex_w;
    logic [15:0] limit;
    logic [63:0] base;
    logic [15:0] source_word;
  } cmd_t;

endpackage

// ===== hw/rtl/xstg_front.sv =====
module xstg_front
  import xstg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [MemSizeWidth-1:0] cfg_wdata_i,
  input  req_t                    req_i,
  output cmd_t                    cmd_o
);

  logic [MemSizeWidth-1:0] mem_size_q;
  logic                    oob;
  logic                    non_canon;
  op_e                     op;
  logic [63:0]             base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MEM_SIZE_RESET;
    end else if (cfg_we_i) begin
      mem_size_q <= cfg_wdata_i;
    end
  end

  // address + 10 beyond memory size, evaluated without wrap
  assign oob = ({1'b0, req_i.address} + BOUND_SPAN) >
               {{(65 - MemSizeWidth){1'b0}}, mem_size_q};

  assign non_canon = !((&req_i.address[63:47]) || !(|req_i.address[63:47]));

  always_comb begin
    op = OP_UD;
    case (grp_e'(req_i.reg_field))
      GRP_SGDT: begin
        if (req_i.is_memory) op = oob ? OP_SEGV : OP_STORE_GDT;
        else if (req_i.rm_field >= 3'd1 && req_i.rm_field <= 3'd4) op = OP_NOP;
      end
      GRP_SIDT: begin
        if (req_i.is_memory) op = oob ? OP_SEGV : OP_STORE_IDT;
        else if (req_i.rm_field <= 3'd1) op = OP_NOP;
      end
      GRP_LGDT: begin
        if (req_i.is_memory) op = oob ? OP_SEGV : OP_LOAD_GDT;
      end
      GRP_LIDT: begin
        if (req_i.is_memory) op = oob ? OP_SEGV : OP_LOAD_IDT;
      end
      GRP_SMSW: begin
        op = req_i.is_memory ? OP_SMSW_MEM : OP_SMSW_REG;
      end
      GRP_LMSW: begin
        op = OP_LMSW;
      end
      GRP_INVLPG: begin
        if (req_i.is_memory) op = (req_i.long_mode && non_canon) ? OP_NOP : OP_INVAL;
        else if (req_i.rm_field == 3'd1) op = OP_RDTSCP;
        else if (req_i.rm_field == 3'd0) op = OP_NOP;
      end
      default: op = OP_UD;
    endcase
  end

  // load base is trimmed to the operand size here
  always_comb begin
    if (req_i.long_mode) base = req_i.loaded_base;
    else if (req_i.operand16) base = req_i.loaded_base & MASK24;
    else base = req_i.loaded_base & MASK32;
  end

  assign cmd_o.op          = op;
  assign cmd_o.long_mode   = req_i.long_mode;
  assign cmd_o.operand16   = req_i.operand16;
  assign cmd_o.rex_w       = req_i.rex_w;
  assign cmd_o.limit       = req_i.loaded_limit;
  assign cmd_o.base        = base;
  assign cmd_o.source_word = req_i.source_word;

endmodule

// ===== hw/rtl/xstg_cmd_fifo.sv =====
module xstg_cmd_fifo
  import xstg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// ===== hw/rtl/xstg_back.sv =====
module xstg_back
  import xstg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output rsp_t rsp_o
);

  logic [15:0] gdt_limit_q, gdt_limit_d;
  logic [63:0] gdt_base_q, gdt_base_d;
  logic [15:0] idt_limit_q, idt_limit_d;
  logic [63:0] idt_base_q, idt_base_d;
  logic [63:0] cr0_q, cr0_d;

  rsp_t       out_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       exec, do_pop;
  rsp_t       rsp;
  logic [3:0] tbl_len;

  assign exec      = !cmd_empty_i && (cnt_q != 2'd2);
  assign cmd_pop_o = exec;
  assign empty_o   = (cnt_q == 2'd0);
  assign do_pop    = pop_i && !empty_o;
  assign rsp_o     = out_q[rd_ptr_q];
  assign tbl_len   = cmd_i.long_mode ? LONG_TABLE_BYTES : SHORT_TABLE_BYTES;

  always_comb begin
    rsp         = '0;
    rsp.status  = STATUS_DONE;
    rsp.reg_width = REG_WIDTH_16;
    gdt_limit_d = gdt_limit_q;
    gdt_base_d  = gdt_base_q;
    idt_limit_d = idt_limit_q;
    idt_base_d  = idt_base_q;
    cr0_d       = cr0_q;
    case (cmd_i.op)
      OP_NOP:    rsp.status = STATUS_DONE;
      OP_UD:     rsp.status = STATUS_UD;
      OP_SEGV:   rsp.status = STATUS_SEGV;
      OP_RDTSCP: rsp.status = STATUS_RDTSCP;
      OP_INVAL:  rsp.status = STATUS_INVAL;
      OP_STORE_GDT: begin
        rsp.mem_write    = 1'b1;
        rsp.write_length = tbl_len;
        rsp.write_limit  = gdt_limit_q;
        rsp.write_base   = cmd_i.long_mode ? gdt_base_q : (gdt_base_q & MASK32);
      end
      OP_STORE_IDT: begin
        rsp.mem_write    = 1'b1;
        rsp.write_length = tbl_len;
        rsp.write_limit  = idt_limit_q;
        rsp.write_base   = cmd_i.long_mode ? idt_base_q : (idt_base_q & MASK32);
      end
      OP_LOAD_GDT: begin
        rsp.read_length = tbl_len;
        gdt_limit_d     = cmd_i.limit;
        gdt_base_d      = cmd_i.base;
      end
      OP_LOAD_IDT: begin
        rsp.read_length = tbl_len;
        idt_limit_d     = cmd_i.limit;
        idt_base_d      = cmd_i.base;
      end
      OP_SMSW_MEM: begin
        rsp.mem_write    = 1'b1;
        rsp.write_length = MSW_STORE_BYTES;
        rsp.write_limit  = cr0_q[15:0];
      end
      OP_SMSW_REG: begin
        rsp.reg_write = 1'b1;
        if (cmd_i.rex_w) begin
          rsp.reg_width = REG_WIDTH_64;
          rsp.reg_value = cr0_q;
        end else if (!cmd_i.operand16) begin
          rsp.reg_width = REG_WIDTH_32;
          rsp.reg_value = cr0_q & MASK32;
        end else begin
          rsp.reg_width = REG_WIDTH_16;
          rsp.reg_value = {48'd0, cr0_q[15:0]};
        end
      end
      OP_LMSW: begin
        // mp/em/ts replaced, pe can only be set
        cr0_d = {cr0_q[63:4], cmd_i.source_word[3:1], cr0_q[0] | cmd_i.source_word[0]};
      end
      default: rsp.status = STATUS_UD;
    endcase
  end

  assign cnt_d = cnt_q + {1'b0, exec} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gdt_limit_q <= '0;
      gdt_base_q  <= '0;
      idt_limit_q <= '0;
      idt_base_q  <= '0;
      cr0_q       <= '0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      if (exec) begin
        gdt_limit_q <= gdt_limit_d;
        gdt_base_q  <= gdt_base_d;
        idt_limit_q <= idt_limit_d;
        idt_base_q  <= idt_base_d;
        cr0_q       <= cr0_d;
        wr_ptr_q    <= !wr_ptr_q;
      end
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) out_q[wr_ptr_q] <= rsp;
  end

endmodule

// ===== hw/rtl/x86_system_table_group_exec.sv =====
// channel   | handshake         | payload
// request   | push / full       | req_i  (req_t)
// result    | empty / pop       | rsp_o  (rsp_t)
// config    | cfg_we_i          | cfg_wdata_i (memory size, 33 bits)
//
// one request per cycle sustained while the receiver keeps popping; a result shows on
// the ports once its request has passed the command and result queues (front decode
// into a 2-entry command queue, back execute into a 2-entry result queue)
// both queues stall independently; full only rises when both are backed up
// reset clears all table registers and cr0, memory size resets to 256 MiB
module x86_system_table_group_exec
  import xstg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [MemSizeWidth-1:0] cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  req_t                    req_i,
  output logic                    empty,
  input  logic                    pop,
  output rsp_t                    rsp_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_empty;
  logic queue_pop;

  xstg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_o       (front_cmd)
  );

  xstg_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .cmd_o   (queue_cmd)
  );

  xstg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== tb/sv/tb_x86_system_table_group_exec.sv =====
`timescale 1ns / 1ps

module tb_x86_system_table_group_exec;
  import xstg_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemsPerPhase = 285;

  // register-form rm encodings within the group
  localparam logic [2:0] RM_SWAPGS    = 3'd0;
  localparam logic [2:0] RM_RDTSCP    = 3'd1;
  localparam logic [2:0] RM_VMX_FIRST = 3'd1;
  localparam logic [2:0] RM_VMX_LAST  = 3'd4;
  localparam logic [2:0] RM_MWAIT     = 3'd1;
  localparam logic [2:0] RM_TOP       = 3'd7;

  localparam logic [32:0] MEM_SIZE_MIN = 33'd16;
  localparam logic [32:0] MEM_SIZE_MAX = 33'h1_0000_0000;
  localparam logic [63:0] CANON_HI_EDGE = 64'h0000_8000_0000_0000;
  localparam logic [63:0] CANON_LO_EDGE = 64'hffff_8000_0000_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [32:0]       cfg_wdata_i = '0;
  logic              push = 1'b0;
  logic              full;
  req_t              req_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  rsp_t              rsp_o;

  // shadow of the block's architectural state
  logic [15:0]       gdtr_limit;
  logic [63:0]       gdtr_base;
  logic [15:0]       idtr_limit;
  logic [63:0]       idtr_base;
  logic [63:0]       cr0_q;
  logic [32:0]       mem_size_q;

  rsp_t              exp_rsp_q[$];
  int unsigned       errors = 0;
  int unsigned       burst_left = 0;
  int unsigned       idle_cycles = 0;
  logic [9:0]        rx_cycle = '0;

  x86_system_table_group_exec u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic rsp_t exec_group_op(req_t r);
    rsp_t o;
    logic seg_fault;
    logic [63:0] base;
    logic [63:0] canon_sum;
    o = '0;
    o.status = STATUS_DONE;
    o.reg_width = REG_WIDTH_16;
    // bound check is done on the unwrapped sum
    seg_fault = ({1'b0, r.address} + BOUND_SPAN) > {32'b0, mem_size_q};
    canon_sum = r.address + CANON_HI_EDGE;
    case (grp_e'(r.reg_field))
      GRP_SGDT, GRP_SIDT: begin
        if (r.is_memory) begin
          if (seg_fault) begin
            o.status = STATUS_SEGV;
          end else begin
            base = (r.reg_field == GRP_SGDT) ? gdtr_base : idtr_base;
            o.mem_write = 1'b1;
            o.write_limit = (r.reg_field == GRP_SGDT) ? gdtr_limit : idtr_limit;
            o.write_length = r.long_mode ? LONG_TABLE_BYTES : SHORT_TABLE_BYTES;
            o.write_base = r.long_mode ? base : (base & MASK32);
          end
        end else if (r.reg_field == GRP_SGDT) begin
          if (r.rm_field < RM_VMX_FIRST || r.rm_field > RM_VMX_LAST) o.status = STATUS_UD;
        end else if (r.rm_field > RM_MWAIT) begin
          o.status = STATUS_UD;
        end
      end
      GRP_LGDT, GRP_LIDT: begin
        if (!r.is_memory) begin
          o.status = STATUS_UD;
        end else if (seg_fault) begin
          o.status = STATUS_SEGV;
        end else begin
          base = r.loaded_base;
          if (r.long_mode) begin
            o.read_length = LONG_TABLE_BYTES;
          end else begin
            base &= r.operand16 ? MASK24 : MASK32;
            o.read_length = SHORT_TABLE_BYTES;
          end
          if (r.reg_field == GRP_LGDT) begin
            gdtr_limit = r.loaded_limit;
            gdtr_base = base;
          end else begin
            idtr_limit = r.loaded_limit;
            idtr_base = base;
          end
        end
      end
      GRP_SMSW: begin
        if (r.is_memory) begin
          o.mem_write = 1'b1;
          o.write_length = MSW_STORE_BYTES;
          o.write_limit = cr0_q[15:0];
        end else begin
          o.reg_write = 1'b1;
          if (r.rex_w) begin
            o.reg_width = REG_WIDTH_64;
            o.reg_value = cr0_q;
          end else if (!r.operand16) begin
            o.reg_width = REG_WIDTH_32;
            o.reg_value = cr0_q & MASK32;
          end else begin
            o.reg_width = REG_WIDTH_16;
            o.reg_value = {48'b0, cr0_q[15:0]};
          end
        end
      end
      GRP_LMSW: begin
        // pe can be set but never cleared
        cr0_q = {cr0_q[63:4], r.source_word[3:1], cr0_q[0] | r.source_word[0]};
      end
      GRP_INVLPG: begin
        if (r.is_memory) begin
          if (!(r.long_mode && canon_sum >= 64'h0001_0000_0000_0000)) o.status = STATUS_INVAL;
        end else if (r.rm_field == RM_RDTSCP) begin
          o.status = STATUS_RDTSCP;
        end else if (r.rm_field != RM_SWAPGS) begin
          o.status = STATUS_UD;
        end
      end
      default: o.status = STATUS_UD;
    endcase
    return o;
  endfunction

  function automatic req_t make_req(grp_e g, logic [2:0] rm, logic mem, logic lm,
                                    logic o16, logic rexw, logic [63:0] addr,
                                    logic [15:0] lim, logic [63:0] base,
                                    logic [15:0] src);
    req_t r;
    r.reg_field = g;
    r.rm_field = rm;
    r.is_memory = mem;
    r.long_mode = lm;
    r.operand16 = o16;
    r.rex_w = rexw;
    r.address = addr;
    r.loaded_limit = lim;
    r.loaded_base = base;
    r.source_word = src;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    logic [63:0] hi;
    logic [191:0] rnd;
    int unsigned pick;
    hi = {31'b0, mem_size_q} - 64'd10;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = rnd[$bits(req_t)-1:0];
    r.is_memory = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      r.address = {32'b0, $urandom_range(0, hi[31:0])};
    end else if (pick < 6) begin
      // straddle the fault bound
      r.address = hi + 64'($urandom_range(0, 6)) - 64'd3;
    end else if (pick < 8) begin
      r.address = ($urandom_range(0, 1) ? CANON_HI_EDGE : CANON_LO_EDGE)
                  + 64'($urandom_range(0, 3)) - 64'd2;
    end else begin
      r.address = {$urandom, $urandom};
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    burst_left--;
    push <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    exp_rsp_q.push_back(exec_group_op(r));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    while (exp_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_memory_size(input logic [32:0] size);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mem_size_q = size;
  endtask

  task automatic test_table_ops();
    set_memory_size(MEM_SIZE_RESET);
    send_req(make_req(GRP_LGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'h1000, 16'hffff,
                      '1, 16'h0));
    send_req(make_req(GRP_SGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'h2000, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SGDT, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 64'h2000, 16'h0, '0, 16'h0));
    // 16-bit operand masks the base to 24 bits
    send_req(make_req(GRP_LIDT, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 64'h3000, 16'h8001,
                      '1, 16'h0));
    send_req(make_req(GRP_SIDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'h4000, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_LIDT, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 64'h3000, 16'h0,
                      '1, 16'h0));
    send_req(make_req(GRP_SIDT, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 64'h4000, 16'h0, '0, 16'h0));
    // long mode wins over the 16-bit operand
    send_req(make_req(GRP_LGDT, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 64'h0, 16'h1234,
                      64'h8765_4321_dead_beef, 16'h0));
    send_req(make_req(GRP_LGDT, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 64'h0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'h0, 16'h0, '0, 16'h0));
  endtask

  task automatic test_msw();
    send_req(make_req(GRP_LMSW, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0, 16'hffff));
    send_req(make_req(GRP_SMSW, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SMSW, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SMSW, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, '0, 16'h0, '0, 16'h0));
    // clearing pe through lmsw is not possible
    send_req(make_req(GRP_LMSW, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, '1, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SMSW, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, '1, 16'h0, '0, 16'h0));
  endtask

  task automatic test_group_misc();
    send_req(make_req(GRP_INVLPG, RM_SWAPGS, 1'b0, 1'b1, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_INVLPG, RM_RDTSCP, 1'b0, 1'b1, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_INVLPG, RM_TOP, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SGDT, RM_SWAPGS, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SGDT, RM_VMX_LAST, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SIDT, RM_MWAIT + 3'd1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0,
                      16'h0));
    send_req(make_req(GRP_RSVD, RM_TOP, 1'b1, 1'b0, 1'b0, 1'b0, '0, 16'h0, '0, 16'h0));
    // canonical edges of invlpg in long mode, and one outside long mode
    send_req(make_req(GRP_INVLPG, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, CANON_HI_EDGE, 16'h0, '0,
                      16'h0));
    send_req(make_req(GRP_INVLPG, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, CANON_LO_EDGE, 16'h0, '0,
                      16'h0));
    send_req(make_req(GRP_INVLPG, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, CANON_HI_EDGE - 64'd1,
                      16'h0, '0, 16'h0));
    send_req(make_req(GRP_INVLPG, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, CANON_HI_EDGE, 16'h0, '0,
                      16'h0));
  endtask

  task automatic test_bound_fault();
    set_memory_size(MEM_SIZE_MIN);
    send_req(make_req(GRP_SGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd6, 16'h0, '0, 16'h0));
    send_req(make_req(GRP_SGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd7, 16'h0, '0, 16'h0));
    // faulting loads leave the table untouched
    send_req(make_req(GRP_LGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'd7, 16'h5555, '1, 16'h0));
    send_req(make_req(GRP_LGDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, '1, 16'h5555, '1, 16'h0));
    set_memory_size(MEM_SIZE_MAX);
    send_req(make_req(GRP_SIDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'hffff_fff6, 16'h0, '0,
                      16'h0));
    send_req(make_req(GRP_SIDT, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 64'hffff_fff7, 16'h0, '0,
                      16'h0));
  endtask

  task automatic test_random_traffic();
    logic [32:0] sizes [6];
    sizes[0] = MEM_SIZE_RESET;
    sizes[1] = MEM_SIZE_MIN;
    sizes[2] = {1'b0, $urandom_range(16, 32'hffff_ffff)};
    sizes[3] = MEM_SIZE_MAX;
    sizes[4] = 33'd4096;
    sizes[5] = {1'b0, $urandom_range(16, 32'hffff_ffff)};
    foreach (sizes[p]) begin
      set_memory_size(sizes[p]);
      repeat (ItemsPerPhase) send_req(random_req());
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && pop && !empty) begin
      if (exp_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, rsp_o);
      end else begin
        want = exp_rsp_q.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_o.status));
        check_field("mem_write", 64'(want.mem_write), 64'(rsp_o.mem_write));
        check_field("write_length", 64'(want.write_length), 64'(rsp_o.write_length));
        check_field("write_limit", 64'(want.write_limit), 64'(rsp_o.write_limit));
        check_field("write_base", want.write_base, rsp_o.write_base);
        check_field("read_length", 64'(want.read_length), 64'(rsp_o.read_length));
        check_field("reg_write", 64'(want.reg_write), 64'(rsp_o.reg_write));
        check_field("reg_width", 64'(want.reg_width), 64'(rsp_o.reg_width));
        check_field("reg_value", want.reg_value, rsp_o.reg_value);
      end
    end
  end

  // receiver stall pattern: free-running, random, one in four, long stalls
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 10'd1;
    case (rx_cycle[9:8])
      2'd0: pop <= 1'b1;
      2'd1: pop <= 1'($urandom_range(0, 1));
      2'd2: pop <= (rx_cycle[1:0] == 2'd0);
      default: pop <= !rx_cycle[4];
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("[x86_system_table_group_exec] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    gdtr_limit = '0;
    gdtr_base = '0;
    idtr_limit = '0;
    idtr_base = '0;
    cr0_q = '0;
    mem_size_q = MEM_SIZE_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_ops();
    test_msw();
    test_group_misc();
    test_bound_fault();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[x86_system_table_group_exec] OK");
    end else begin
      $display("[x86_system_table_group_exec] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/xstg_pkg.sv
hw/rtl/xstg_front.sv
hw/rtl/xstg_cmd_fifo.sv
hw/rtl/xstg_back.sv
hw/rtl/x86_system_table_group_exec.sv
tb/sv/tb_x86_system_table_group_exec.sv
